@@ rtl/tfr_pkg.sv @@
// Package with shared constants, command codes, queue entry type and font lookup.
package tfr_pkg;

  localparam int unsigned DisplayWidth  = 128;
  localparam int unsigned DisplayHeight = 64;
  localparam int unsigned PageCount     = DisplayHeight / 8;
  localparam int unsigned StoreBytes    = DisplayWidth * PageCount;
  localparam int unsigned AddrW         = $clog2(StoreBytes);
  localparam int unsigned ColW          = $clog2(DisplayWidth);
  localparam int unsigned PageW         = (PageCount > 1) ? $clog2(PageCount) : 1;
  localparam int unsigned QueueDepth    = 2;

  typedef enum logic [2:0] {
    CmdChar       = 3'd0,
    CmdSetCursor  = 3'd1,
    CmdClear      = 3'd2,
    CmdPixel      = 3'd3,
    CmdRead       = 3'd4,
    CmdScaledOrg  = 3'd5,
    CmdScaledChar = 3'd6,
    CmdNone       = 3'd7
  } cmd_e;

  typedef struct packed {
    cmd_e              cmd;
    logic [7:0]        char_code;
    logic [7:0]        new_col;
    logic [7:0]        new_page;
    logic signed [9:0] pos_x;
    logic signed [9:0] pos_y;
    logic              color;
    logic [3:0]        scale;
    logic [9:0]        address;
  } cmd_item_t;

  // One glyph column of the 5x7 font; codes outside the font read as blank.
  function automatic logic [7:0] glyph_col(input logic [7:0] code, input logic [2:0] col);
    logic [7:0] c;
    logic [39:0] g;
    c = code;
    if (c >= 8'h61 && c <= 8'h7A) c = c - 8'd32;
    case (c)
      8'h30: g = 40'h3E_51_49_45_3E;
      8'h31: g = 40'h00_42_7F_40_00;
      8'h32: g = 40'h42_61_51_49_46;
      8'h33: g = 40'h21_41_45_4B_31;
      8'h34: g = 40'h18_14_12_7F_10;
      8'h35: g = 40'h27_45_45_45_39;
      8'h36: g = 40'h3C_4A_49_49_30;
      8'h37: g = 40'h01_71_09_05_03;
      8'h38: g = 40'h36_49_49_49_36;
      8'h39: g = 40'h06_49_49_29_1E;
      8'h41: g = 40'h7E_11_11_11_7E;
      8'h42: g = 40'h7F_49_49_49_36;
      8'h43: g = 40'h3E_41_41_41_22;
      8'h44: g = 40'h7F_41_41_22_1C;
      8'h45: g = 40'h7F_49_49_49_41;
      8'h46: g = 40'h7F_09_09_09_01;
      8'h47: g = 40'h3E_41_49_49_7A;
      8'h48: g = 40'h7F_08_08_08_7F;
      8'h49: g = 40'h00_41_7F_41_00;
      8'h4A: g = 40'h20_40_41_3F_01;
      8'h4B: g = 40'h7F_08_14_22_41;
      8'h4C: g = 40'h7F_40_40_40_40;
      8'h4D: g = 40'h7F_02_0C_02_7F;
      8'h4E: g = 40'h7F_04_08_10_7F;
      8'h4F: g = 40'h3E_41_41_41_3E;
      8'h50: g = 40'h7F_09_09_09_06;
      8'h51: g = 40'h3E_41_51_21_5E;
      8'h52: g = 40'h7F_09_19_29_46;
      8'h53: g = 40'h46_49_49_49_31;
      8'h54: g = 40'h01_01_7F_01_01;
      8'h55: g = 40'h3F_40_40_40_3F;
      8'h56: g = 40'h1F_20_40_20_1F;
      8'h57: g = 40'h7F_20_18_20_7F;
      8'h58: g = 40'h63_14_08_14_63;
      8'h59: g = 40'h07_08_70_08_07;
      8'h5A: g = 40'h61_51_49_45_43;
      8'h3A: g = 40'h00_36_36_00_00;
      8'h2D: g = 40'h08_08_08_08_08;
      8'h2E: g = 40'h00_60_60_00_00;
      default: g = 40'h0;
    endcase
    case (col)
      3'd0: return g[39:32];
      3'd1: return g[31:24];
      3'd2: return g[23:16];
      3'd3: return g[15:8];
      3'd4: return g[7:0];
      default: return 8'h00;
    endcase
  endfunction

endpackage

@@ rtl/tfr_front.sv @@
// Front end: accepts command items and holds them in a short queue for the back end.
module tfr_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  output logic               full_o,
  input  tfr_pkg::cmd_item_t item_i,
  output logic               avail_o,
  input  logic               take_i,
  output tfr_pkg::cmd_item_t item_o
);
  import tfr_pkg::*;

  cmd_item_t slot_q [QueueDepth];
  logic [$clog2(QueueDepth)-1:0] wr_q, rd_q;
  logic [$clog2(QueueDepth):0] cnt_q;
  logic do_push, do_pop;

  assign full_o  = (cnt_q == ($clog2(QueueDepth)+1)'(QueueDepth));
  assign avail_o = (cnt_q != '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = take_i && avail_o;
  assign item_o  = slot_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) slot_q[wr_q] <= item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + 1'b1;
      if (do_pop)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (($clog2(QueueDepth)+1)'(do_push)) - (($clog2(QueueDepth)+1)'(do_pop));
    end
  end

endmodule

@@ rtl/tfr_back.sv @@
// Back end: executes commands against the frame store and produces result items.
module tfr_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               avail_i,
  output logic               take_o,
  input  tfr_pkg::cmd_item_t item_i,
  output logic               empty_o,
  input  logic               pop_i,
  output logic [7:0]         read_data_o
);
  import tfr_pkg::*;

  typedef enum logic [2:0] {
    StIdle, StClear, StText, StRmw, StScaled, StRead, StOut
  } state_e;

  localparam int unsigned AddrCntW = AddrW + 1;

  state_e            state_q;
  cmd_item_t         cur_q;
  logic [7:0]        mem [StoreBytes];
  logic [7:0]        rdata_q;
  logic [AddrCntW-1:0] cnt_q;
  logic [7:0]        col_q, page_q;
  logic signed [15:0] org_x_q, scx_q, scy_q;
  logic [3:0]        fac_q;
  logic [7:0]        res_q;
  logic [7:0]        data_q;
  logic              res_valid_q;
  logic              res_load;
  // scaled glyph walk: column, row, sub x, sub y
  logic [2:0]        gcol_q, grow_q;
  logic [3:0]        sx_q, sy_q;
  logic              rmw_ph_q;
  logic [AddrW-1:0]  rmw_addr_q;
  logic [2:0]        rmw_bit_q;
  logic              rmw_on_q;
  logic              rmw_scaled_q;

  logic              we;
  logic [AddrW-1:0]  waddr, raddr;
  logic [7:0]        wdata;

  // Plot target of the current scaled-glyph dot.
  logic signed [17:0] dot_x, dot_y;
  logic [7:0]         gbits;
  logic [6:0]         col_off, row_off;
  assign col_off = 7'(gcol_q) * 7'(fac_q);
  assign row_off = 7'(grow_q) * 7'(fac_q);
  assign dot_x   = 18'(scx_q) + 18'(col_off) + 18'(sx_q);
  assign dot_y   = 18'(scy_q) + 18'(row_off) + 18'(sy_q);
  assign gbits   = glyph_col(cur_q.char_code, gcol_q);

  logic dot_on, dot_in;
  assign dot_on = gbits[grow_q];
  assign dot_in = (dot_x >= 0) && (dot_x < 18'(DisplayWidth)) &&
                  (dot_y >= 0) && (dot_y < 18'(DisplayHeight));

  logic signed [17:0] sat_in_x, sat_in_y;
  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    if (v > 18'sd32767) return 16'sh7FFF;
    if (v < -18'sd32768) return -16'sh8000;
    return v[15:0];
  endfunction
  assign sat_in_x = 18'(scx_q) + 18'(5 * fac_q) + 18'sd1;
  assign sat_in_y = 18'(scy_q) + 18'({fac_q, 3'b000});

  logic [8:0] col_plus6;
  assign col_plus6 = {1'b0, col_q} + 9'd6;

  // In-range check of the pixel for the plot command.
  logic px_in;
  assign px_in = (cur_q.pos_x >= 0) && (cur_q.pos_x < 10'(DisplayWidth)) &&
                 (cur_q.pos_y >= 0) && (cur_q.pos_y < 10'(DisplayHeight));

  // The result register takes a new item once the waiting one is gone or leaves now.
  assign res_load = (state_q == StOut) && (!res_valid_q || pop_i);

  assign take_o  = (state_q == StIdle) && avail_i;
  assign empty_o = !res_valid_q;
  assign read_data_o = data_q;

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rdata_q <= mem[raddr];
  end

  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    raddr = rmw_addr_q;
    unique case (state_q)
      StClear: begin
        we    = 1'b1;
        waddr = cnt_q[AddrW-1:0];
      end
      StText: begin
        we    = 1'b1;
        waddr = {page_q[PageW-1:0], col_q[ColW-1:0]} + AddrW'(cnt_q[2:0]);
        wdata = (cnt_q[2:0] == 3'd5) ? 8'h00 : glyph_col(cur_q.char_code, cnt_q[2:0]);
      end
      StRmw: begin
        if (rmw_ph_q) begin
          we    = 1'b1;
          waddr = rmw_addr_q;
          wdata = rmw_on_q ? (rdata_q | (8'd1 << rmw_bit_q))
                           : (rdata_q & ~(8'd1 << rmw_bit_q));
        end
      end
      StRead: raddr = cur_q.address[AddrW-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StClear;
      cnt_q        <= '0;
      col_q        <= '0;
      page_q       <= '0;
      org_x_q      <= '0;
      scx_q        <= '0;
      scy_q        <= '0;
      fac_q        <= 4'd1;
      res_q        <= '0;
      data_q       <= '0;
      res_valid_q  <= 1'b0;
      gcol_q       <= '0;
      grow_q       <= '0;
      sx_q         <= '0;
      sy_q         <= '0;
      rmw_ph_q     <= 1'b0;
      rmw_addr_q   <= '0;
      rmw_bit_q    <= '0;
      rmw_on_q     <= 1'b0;
      rmw_scaled_q <= 1'b0;
      cur_q        <= '0;
    end else begin
      if (res_load) begin
        res_valid_q <= 1'b1;
        data_q      <= res_q;
      end else if (pop_i && res_valid_q) begin
        res_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (avail_i) begin
            cur_q <= item_i;
            cnt_q <= '0;
            res_q <= '0;
            unique case (item_i.cmd)
              CmdChar: begin
                if (item_i.char_code == 8'd10) begin
                  col_q <= '0;
                  if (page_q != 8'hFF) page_q <= page_q + 8'd1;
                  state_q <= StOut;
                end else begin
                  logic [7:0] pg;
                  pg = page_q;
                  if ({1'b0, col_q} + 9'd6 >= 9'(DisplayWidth)) begin
                    col_q <= '0;
                    if (page_q != 8'hFF) pg = page_q + 8'd1;
                    page_q <= pg;
                  end
                  state_q <= (pg >= 8'(PageCount)) ? StOut : StText;
                end
              end
              CmdSetCursor: begin
                col_q   <= item_i.new_col;
                page_q  <= item_i.new_page;
                state_q <= StOut;
              end
              CmdClear: begin
                col_q   <= '0;
                page_q  <= '0;
                state_q <= StClear;
              end
              CmdPixel: begin
                rmw_addr_q   <= AddrW'({item_i.pos_y[PageW+2:3], item_i.pos_x[ColW-1:0]});
                rmw_bit_q    <= item_i.pos_y[2:0];
                rmw_on_q     <= item_i.color;
                rmw_ph_q     <= 1'b0;
                rmw_scaled_q <= 1'b0;
                state_q      <= StRmw;
              end
              CmdRead: state_q <= StRead;
              CmdScaledOrg: begin
                org_x_q <= 16'(item_i.pos_x);
                scx_q   <= 16'(item_i.pos_x);
                scy_q   <= 16'(item_i.pos_y);
                fac_q   <= (item_i.scale == 4'd0) ? 4'd1 : item_i.scale;
                state_q <= StOut;
              end
              CmdScaledChar: begin
                if (item_i.char_code == 8'd10) begin
                  scx_q   <= org_x_q;
                  scy_q   <= sat16(sat_in_y);
                  state_q <= StOut;
                end else begin
                  gcol_q  <= '0;
                  grow_q  <= '0;
                  sx_q    <= '0;
                  sy_q    <= '0;
                  state_q <= StScaled;
                end
              end
              default: state_q <= StOut;
            endcase
          end
        end
        StClear: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == AddrCntW'(StoreBytes - 1)) state_q <= cur_q.cmd == CmdClear ? StOut : StIdle;
        end
        StText: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q[2:0] == 3'd5) begin
            col_q   <= col_plus6[7:0];
            state_q <= StOut;
          end
        end
        StRmw: begin
          if (!rmw_scaled_q && !px_in) begin
            state_q <= StOut;
          end else if (!rmw_ph_q) begin
            rmw_ph_q <= 1'b1;
          end else begin
            rmw_ph_q <= 1'b0;
            state_q  <= rmw_scaled_q ? StScaled : StOut;
          end
        end
        StScaled: begin
          // Advance the walk; plot visible dots through a read-modify-write.
          logic last_sy, last_sx, last_row;
          last_sy  = (sy_q == fac_q - 4'd1);
          last_sx  = (sx_q == fac_q - 4'd1);
          last_row = (grow_q == 3'd6);
          if (dot_on && dot_in && !rmw_scaled_q) begin
            rmw_addr_q   <= AddrW'({dot_y[PageW+2:3], dot_x[ColW-1:0]});
            rmw_bit_q    <= dot_y[2:0];
            rmw_on_q     <= 1'b1;
            rmw_ph_q     <= 1'b0;
            rmw_scaled_q <= 1'b1;
            state_q      <= StRmw;
          end else begin
            rmw_scaled_q <= 1'b0;
            if (!dot_on || (last_sy && last_sx)) begin
              sx_q <= '0;
              sy_q <= '0;
              if (last_row) begin
                grow_q <= '0;
                if (gcol_q == 3'd4) begin
                  scx_q   <= sat16(sat_in_x);
                  state_q <= StOut;
                end else begin
                  gcol_q <= gcol_q + 3'd1;
                end
              end else begin
                grow_q <= grow_q + 3'd1;
              end
            end else if (last_sy) begin
              sy_q <= '0;
              sx_q <= sx_q + 4'd1;
            end else begin
              sy_q <= sy_q + 4'd1;
            end
          end
        end
        StRead: begin
          if (cnt_q[0]) begin
            res_q   <= ({1'b0, cur_q.address} < 11'(StoreBytes)) ? rdata_q : 8'h00;
            state_q <= StOut;
          end
          cnt_q <= cnt_q + 1'b1;
        end
        StOut: begin
          if (res_load) state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule

@@ rtl/text_framebuffer_renderer_core.sv @@
// Top level of the text frame store renderer with a 5x7 character generator.
//   channel | direction | handshake        | fields
//   command | in        | push_i / full_o  | command .. address
//   result  | out       | empty_o / pop_i  | read_data
// A text character dispatches, makes six store writes and loads its result. Newline,
// set cursor, scaled origin, a character below the last page and unused codes go
// straight to the result load. A read byte reads the store before the load; a plot
// reads, then writes back its byte, or skips both when clipped; clear writes every byte.
// A scaled glyph walks 35 dots; each visible lit subpixel takes a read-modify-write.
// After reset a pass zeroes the store; no item runs meanwhile.
// Two items queue ahead of the engine; it stalls while an unpopped result holds the output.
module text_framebuffer_renderer_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  logic [2:0]        command_i,
  input  logic [7:0]        char_code_i,
  input  logic [7:0]        new_col_i,
  input  logic [7:0]        new_page_i,
  input  logic signed [9:0] pos_x_i,
  input  logic signed [9:0] pos_y_i,
  input  logic              color_i,
  input  logic [3:0]        scale_i,
  input  logic [9:0]        address_i,
  output logic              empty,
  input  logic              pop,
  output logic [7:0]        read_data_o
);
  import tfr_pkg::*;

  cmd_item_t in_item, q_item;
  logic      q_avail, q_take;

  assign in_item.cmd       = cmd_e'(command_i);
  assign in_item.char_code = char_code_i;
  assign in_item.new_col   = new_col_i;
  assign in_item.new_page  = new_page_i;
  assign in_item.pos_x     = pos_x_i;
  assign in_item.pos_y     = pos_y_i;
  assign in_item.color     = color_i;
  assign in_item.scale     = scale_i;
  assign in_item.address   = address_i;

  tfr_front u_front (
    .clk_i, .rst_ni, .push_i(push), .full_o(full), .item_i(in_item),
    .avail_o(q_avail), .take_i(q_take), .item_o(q_item)
  );

  tfr_back u_back (
    .clk_i, .rst_ni, .avail_i(q_avail), .take_o(q_take), .item_i(q_item),
    .empty_o(empty), .pop_i(pop), .read_data_o
  );

endmodule

@@ rtl/tfr_checker.sv @@
// Port-level checker for the renderer top level, with its bind statement.
module tfr_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       push,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [7:0] read_data_o
);
  // Items accepted and not yet answered by a popped result.
  logic [3:0] pending_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_q + 4'(push && !full) - 4'(pop && !empty);
    end
  end

  a_res_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> $stable(read_data_o)) else $error("result changed while waiting");
  a_empty_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> !empty) else $error("result dropped");
  a_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$isunknown({full, empty})) else $error("handshake flag unknown");
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (pending_q != '0)) else $error("result without an item");
endmodule

bind text_framebuffer_renderer_core tfr_checker u_checker (.*);
